// ===== rtl/stl_pkg.sv =====
package stl_pkg;

  typedef enum logic [6:0] {
    MODE_IDLE  = 7'b0000001,
    MODE_IDENT = 7'b0000010,
    MODE_INT   = 7'b0000100,
    MODE_FRAC  = 7'b0001000,
    MODE_STR   = 7'b0010000,
    MODE_ESC   = 7'b0100000,
    MODE_SEL   = 7'b1000000
  } mode_t;

  localparam logic [4:0] KIND_IDENT    = 5'd0;
  localparam logic [4:0] KIND_STRING   = 5'd16;
  localparam logic [4:0] KIND_NUMBER   = 5'd17;
  localparam logic [4:0] KIND_SELECTOR = 5'd18;
  localparam logic [4:0] KIND_LBRACE   = 5'd19;
  localparam logic [4:0] KIND_RBRACE   = 5'd20;
  localparam logic [4:0] KIND_LBRACK   = 5'd21;
  localparam logic [4:0] KIND_RBRACK   = 5'd22;
  localparam logic [4:0] KIND_LPAREN   = 5'd23;
  localparam logic [4:0] KIND_RPAREN   = 5'd24;
  localparam logic [4:0] KIND_SEMI     = 5'd25;
  localparam logic [4:0] KIND_COLON    = 5'd26;
  localparam logic [4:0] KIND_EQUAL    = 5'd27;
  localparam logic [4:0] KIND_COMMA    = 5'd28;
  localparam logic [4:0] KIND_DOT      = 5'd29;
  localparam logic [4:0] KIND_UNKNOWN  = 5'd30;
  localparam logic [4:0] KIND_EOF      = 5'd31;

  localparam int NUM_KW = 15;
  localparam int MAX_RES = 4;

  // keyword text, right-justified, first char in the highest used byte
  localparam logic [79:0] KW_TEXT [NUM_KW] = '{
    80'("vir"), 80'("listen"), 80'("delegate"), 80'("animate"), 80'("target"),
    80'("duration"), 80'("easing"), 80'("begin"), 80'("when"), 80'("end"),
    80'("loop"), 80'("direction"), 80'("delay"), 80'("callback"), 80'("at")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd6, 4'd8, 4'd7, 4'd6, 4'd8, 4'd6, 4'd5, 4'd4, 4'd3, 4'd4, 4'd9, 4'd5,
    4'd8, 4'd2
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic [14:0] kw_step(input logic [14:0] m, input logic [3:0] len,
                                          input logic [7:0] c);
    logic [14:0] r;
    int p;
    r = m;
    for (int k = 0; k < NUM_KW; k++) begin
      p = (int'(KW_LEN[k]) - 1 - int'(len)) * 8;
      if (len >= KW_LEN[k]) begin
        r[k] = 1'b0;
      end else if (KW_TEXT[k][p +: 8] != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [4:0] kw_kind(input logic [14:0] m, input logic [3:0] len);
    logic [4:0] r;
    r = KIND_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (m[k] && KW_LEN[k] == len) r = 5'(k + 1);
    end
    return r;
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] r;
    case (c)
      8'h7b: r = KIND_LBRACE;
      8'h7d: r = KIND_RBRACE;
      8'h5b: r = KIND_LBRACK;
      8'h5d: r = KIND_RBRACK;
      8'h28: r = KIND_LPAREN;
      8'h29: r = KIND_RPAREN;
      8'h3b: r = KIND_SEMI;
      8'h3a: r = KIND_COLON;
      8'h3d: r = KIND_EQUAL;
      8'h2c: r = KIND_COMMA;
      8'h2e: r = KIND_DOT;
      default: r = KIND_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/stl_lexer.sv =====
module stl_lexer #(
  parameter int LINE_WIDTH = 20,
  parameter int COLUMN_WIDTH = 16,
  localparam int RW = 15 + LINE_WIDTH + COLUMN_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    char_in,
  input  logic          has_char,
  input  logic          end_of_source,
  output logic [RW-1:0] recs [stl_pkg::MAX_RES],
  output logic [2:0]    rec_n
);

  stl_pkg::mode_t mode_r, mode_nxt;
  logic obp_r, obp_nxt, cbp_r, cbp_nxt, qs_r, qs_nxt;
  logic [14:0] km_r, km_nxt;
  logic [3:0] il_r, il_nxt;
  logic [LINE_WIDTH-1:0] lc_r, lc_nxt;
  logic [COLUMN_WIDTH-1:0] cc_r, cc_nxt, tsc_r, tsc_nxt;
  logic do_idle, skip;

  function automatic logic [RW-1:0] mk(input logic [4:0] kind, input logic [7:0] b,
                                       input logic hb, input logic done,
                                       input logic [LINE_WIDTH-1:0] ln,
                                       input logic [COLUMN_WIDTH-1:0] col);
    return {col, ln, done, hb, b, kind};
  endfunction

  always_comb begin
    mode_nxt = mode_r;
    obp_nxt = obp_r;
    cbp_nxt = cbp_r;
    qs_nxt = qs_r;
    km_nxt = km_r;
    il_nxt = il_r;
    lc_nxt = lc_r;
    cc_nxt = cc_r;
    tsc_nxt = tsc_r;
    rec_n = 3'd0;
    do_idle = 1'b0;
    skip = 1'b0;
    for (int i = 0; i < stl_pkg::MAX_RES; i++) recs[i] = '0;
    if (fire && has_char) begin
      case (mode_nxt)
        stl_pkg::MODE_IDENT: begin
          if (stl_pkg::is_alpha(char_in) || stl_pkg::is_digit(char_in) ||
              char_in == 8'h5f) begin
            km_nxt = stl_pkg::kw_step(km_nxt, il_nxt, char_in);
            if (il_nxt != 4'd15) il_nxt = il_nxt + 4'd1;
            recs[rec_n[1:0]] = mk(5'd0, char_in, 1'b1, 1'b0, '0, '0);
            rec_n = rec_n + 3'd1;
            if (cc_nxt != '1) cc_nxt = cc_nxt + 1'b1;
          end else begin
            recs[rec_n[1:0]] = mk(stl_pkg::kw_kind(km_nxt, il_nxt), 8'd0, 1'b0, 1'b1,
                                  lc_nxt, tsc_nxt);
            rec_n = rec_n + 3'd1;
            mode_nxt = stl_pkg::MODE_IDLE;
            do_idle = 1'b1;
          end
        end
        stl_pkg::MODE_INT, stl_pkg::MODE_FRAC: begin
          if (stl_pkg::is_digit(char_in) ||
              (char_in == 8'h2e && mode_nxt == stl_pkg::MODE_INT)) begin
            recs[rec_n[1:0]] = mk(5'd0, char_in, 1'b1, 1'b0, '0, '0);
            rec_n = rec_n + 3'd1;
            if (cc_nxt != '1) cc_nxt = cc_nxt + 1'b1;
            if (char_in == 8'h2e) mode_nxt = stl_pkg::MODE_FRAC;
          end else begin
            recs[rec_n[1:0]] = mk(stl_pkg::KIND_NUMBER, 8'd0, 1'b0, 1'b1, lc_nxt, tsc_nxt);
            rec_n = rec_n + 3'd1;
            mode_nxt = stl_pkg::MODE_IDLE;
            do_idle = 1'b1;
          end
        end
        stl_pkg::MODE_STR: begin
          if (cc_nxt != '1) cc_nxt = cc_nxt + 1'b1;
          if (char_in == (qs_nxt ? 8'h27 : 8'h22)) begin
            recs[rec_n[1:0]] = mk(stl_pkg::KIND_STRING, 8'd0, 1'b0, 1'b1, lc_nxt, tsc_nxt);
            rec_n = rec_n + 3'd1;
            mode_nxt = stl_pkg::MODE_IDLE;
          end else if (char_in == 8'h5c) begin
            mode_nxt = stl_pkg::MODE_ESC;
          end else begin
            recs[rec_n[1:0]] = mk(5'd0, char_in, 1'b1, 1'b0, '0, '0);
            rec_n = rec_n + 3'd1;
          end
        end
        stl_pkg::MODE_ESC: begin
          if (cc_nxt != '1) cc_nxt = cc_nxt + 1'b1;
          recs[rec_n[1:0]] = mk(5'd0, char_in, 1'b1, 1'b0, '0, '0);
          rec_n = rec_n + 3'd1;
          mode_nxt = stl_pkg::MODE_STR;
        end
        stl_pkg::MODE_SEL: begin
          if (cc_nxt != '1) cc_nxt = cc_nxt + 1'b1;
          if (cbp_nxt) begin
            cbp_nxt = 1'b0;
            if (char_in == 8'h7d) begin
              recs[rec_n[1:0]] = mk(stl_pkg::KIND_SELECTOR, 8'd0, 1'b0, 1'b1,
                                    lc_nxt, tsc_nxt);
              rec_n = rec_n + 3'd1;
              mode_nxt = stl_pkg::MODE_IDLE;
              skip = 1'b1;
            end else begin
              recs[rec_n[1:0]] = mk(5'd0, 8'h7d, 1'b1, 1'b0, '0, '0);
              rec_n = rec_n + 3'd1;
            end
          end
          if (!skip) begin
            if (char_in == 8'h7d) begin
              cbp_nxt = 1'b1;
            end else begin
              recs[rec_n[1:0]] = mk(5'd0, char_in, 1'b1, 1'b0, '0, '0);
              rec_n = rec_n + 3'd1;
            end
          end
        end
        default: begin
          mode_nxt = stl_pkg::MODE_IDLE;
          if (obp_nxt) begin
            obp_nxt = 1'b0;
            if (char_in == 8'h7b) begin
              mode_nxt = stl_pkg::MODE_SEL;
              cbp_nxt = 1'b0;
              if (cc_nxt != '1) cc_nxt = cc_nxt + 1'b1;
            end else begin
              recs[rec_n[1:0]] = mk(stl_pkg::KIND_LBRACE, 8'h7b, 1'b1, 1'b1, lc_nxt, tsc_nxt);
              rec_n = rec_n + 3'd1;
              do_idle = 1'b1;
            end
          end else begin
            do_idle = 1'b1;
          end
        end
      endcase

      // byte seen between tokens
      if (do_idle) begin
        if (stl_pkg::is_space(char_in)) begin
          if (char_in == 8'h0a) begin
            if (lc_nxt != '1) lc_nxt = lc_nxt + 1'b1;
            cc_nxt = COLUMN_WIDTH'(1);
          end else if (cc_nxt != '1) begin
            cc_nxt = cc_nxt + 1'b1;
          end
        end else begin
          tsc_nxt = cc_nxt;
          if (cc_nxt != '1) cc_nxt = cc_nxt + 1'b1;
          if (stl_pkg::is_alpha(char_in) || char_in == 8'h5f) begin
            mode_nxt = stl_pkg::MODE_IDENT;
            km_nxt = stl_pkg::kw_step(15'h7fff, 4'd0, char_in);
            il_nxt = 4'd1;
            recs[rec_n[1:0]] = mk(5'd0, char_in, 1'b1, 1'b0, '0, '0);
            rec_n = rec_n + 3'd1;
          end else if (char_in == 8'h22 || char_in == 8'h27) begin
            mode_nxt = stl_pkg::MODE_STR;
            qs_nxt = (char_in == 8'h27);
          end else if (stl_pkg::is_digit(char_in)) begin
            mode_nxt = stl_pkg::MODE_INT;
            recs[rec_n[1:0]] = mk(5'd0, char_in, 1'b1, 1'b0, '0, '0);
            rec_n = rec_n + 3'd1;
          end else if (char_in == 8'h7b) begin
            obp_nxt = 1'b1;
          end else begin
            recs[rec_n[1:0]] = mk(stl_pkg::punct_kind(char_in), char_in, 1'b1, 1'b1,
                                  lc_nxt, tsc_nxt);
            rec_n = rec_n + 3'd1;
          end
        end
      end
    end

    if (fire && end_of_source) begin
      case (mode_nxt)
        stl_pkg::MODE_IDENT: begin
          recs[rec_n[1:0]] = mk(stl_pkg::kw_kind(km_nxt, il_nxt), 8'd0, 1'b0, 1'b1,
                                lc_nxt, tsc_nxt);
          rec_n = rec_n + 3'd1;
        end
        stl_pkg::MODE_INT, stl_pkg::MODE_FRAC: begin
          recs[rec_n[1:0]] = mk(stl_pkg::KIND_NUMBER, 8'd0, 1'b0, 1'b1, lc_nxt, tsc_nxt);
          rec_n = rec_n + 3'd1;
        end
        stl_pkg::MODE_STR, stl_pkg::MODE_ESC: begin
          recs[rec_n[1:0]] = mk(stl_pkg::KIND_STRING, 8'd0, 1'b0, 1'b1, lc_nxt, tsc_nxt);
          rec_n = rec_n + 3'd1;
        end
        stl_pkg::MODE_SEL: begin
          if (cbp_nxt) begin
            recs[rec_n[1:0]] = mk(5'd0, 8'h7d, 1'b1, 1'b0, '0, '0);
            rec_n = rec_n + 3'd1;
          end
          recs[rec_n[1:0]] = mk(stl_pkg::KIND_SELECTOR, 8'd0, 1'b0, 1'b1, lc_nxt, tsc_nxt);
          rec_n = rec_n + 3'd1;
        end
        default: begin
          if (obp_nxt) begin
            recs[rec_n[1:0]] = mk(stl_pkg::KIND_LBRACE, 8'h7b, 1'b1, 1'b1, lc_nxt, tsc_nxt);
            rec_n = rec_n + 3'd1;
          end
        end
      endcase
      recs[rec_n[1:0]] = mk(stl_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, lc_nxt, cc_nxt);
      rec_n = rec_n + 3'd1;
      mode_nxt = stl_pkg::MODE_IDLE;
      obp_nxt = 1'b0;
      cbp_nxt = 1'b0;
      qs_nxt = 1'b0;
      km_nxt = 15'h7fff;
      il_nxt = 4'd0;
      lc_nxt = LINE_WIDTH'(1);
      cc_nxt = COLUMN_WIDTH'(1);
      tsc_nxt = COLUMN_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stl_pkg::MODE_IDLE;
      obp_r <= 1'b0;
      cbp_r <= 1'b0;
      qs_r <= 1'b0;
      km_r <= 15'h7fff;
      il_r <= 4'd0;
      lc_r <= LINE_WIDTH'(1);
      cc_r <= COLUMN_WIDTH'(1);
      tsc_r <= COLUMN_WIDTH'(1);
    end else begin
      mode_r <= mode_nxt;
      obp_r <= obp_nxt;
      cbp_r <= cbp_nxt;
      qs_r <= qs_nxt;
      km_r <= km_nxt;
      il_r <= il_nxt;
      lc_r <= lc_nxt;
      cc_r <= cc_nxt;
      tsc_r <= tsc_nxt;
    end
  end

endmodule

// ===== rtl/stl_out_fifo.sv =====
module stl_out_fifo #(
  parameter int RW = 51
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [RW-1:0] wr_recs [stl_pkg::MAX_RES],
  input  logic [2:0]    wr_n,
  output logic          space_ok,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [RW-1:0] rd_rec,
  output logic          rd_last
);

  logic [RW:0] mem_r [8];
  logic [2:0] wr_ptr_r, rd_ptr_r;
  logic [3:0] count_r, count_nxt;
  logic pop;

  assign rd_valid = count_r != 4'd0;
  assign pop = rd_valid && rd_ready;
  assign {rd_last, rd_rec} = mem_r[rd_ptr_r];
  // room for a full burst of records from one request
  assign space_ok = count_r <= 4'd4;
  assign count_nxt = count_r + {1'b0, wr_n} - {3'd0, pop};

  always_ff @(posedge clk) begin
    for (int i = 0; i < stl_pkg::MAX_RES; i++) begin
      if (3'(i) < wr_n) mem_r[wr_ptr_r + 3'(i)] <= {(3'(i + 1) == wr_n), wr_recs[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 3'd0;
      rd_ptr_r <= 3'd0;
      count_r <= 4'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + wr_n;
      if (pop) rd_ptr_r <= rd_ptr_r + 3'd1;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/script_token_lexer_top.sv =====
// streaming lexer for a small script dialect
// input channel: one request per source byte; in_tdata is the byte, in_tuser
// says whether the byte is present, in_tlast marks the end of the source
// output channel: token records; byte records carry one value byte, an end
// record closes the token with kind, line and start column; an eof token ends
// the source, after which all lexer state is back at its reset values
// out_tlast flags the final record caused by one input request
// records of a request are registered into the output queue when it is accepted
// throughput: one request per cycle while each makes at most one record and
// out_tready stays high; a request making up to four records drains through an
// 8-entry output queue at one record per cycle while out_tready is high, and
// in_tready drops while fewer than four entries are free
// reset: synchronous active-low, clears the lexer state and empties the queue
// stall: a low out_tready holds the head record; input keeps being taken until
// the queue is near full
module script_token_lexer_top #(
  parameter int LINE_WIDTH = 20,
  parameter int COLUMN_WIDTH = 16,
  localparam int RW = 15 + LINE_WIDTH + COLUMN_WIDTH,
  localparam int DW = ((RW + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // char_in
  input  logic          in_tuser,   // has_char
  input  logic          in_tlast,   // end_of_source
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [DW-1:0] out_tdata,  // kind, text_byte, has_byte, token_done, line, column
  output logic          out_tlast   // last
);

  logic fire;
  logic [RW-1:0] recs [stl_pkg::MAX_RES];
  logic [2:0] rec_n;
  logic [RW-1:0] head;

  assign fire = in_tvalid && in_tready;
  assign out_tdata = DW'(head);

  stl_lexer #(.LINE_WIDTH(LINE_WIDTH), .COLUMN_WIDTH(COLUMN_WIDTH)) u_lexer (
    .clk(clk),
    .rst_n(rst_n),
    .fire(fire),
    .char_in(in_tdata),
    .has_char(in_tuser),
    .end_of_source(in_tlast),
    .recs(recs),
    .rec_n(rec_n)
  );

  stl_out_fifo #(.RW(RW)) u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .wr_recs(recs),
    .wr_n(rec_n),
    .space_ok(in_tready),
    .rd_valid(out_tvalid),
    .rd_ready(out_tready),
    .rd_rec(head),
    .rd_last(out_tlast)
  );

endmodule

// ===== tb/tb_script_token_lexer_top.sv =====
module tb_script_token_lexer_top;

  localparam int LW = 20;
  localparam int CW = 16;
  localparam int DW = 56;
  localparam int NUM_RAND = 145;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN = 300;
  localparam int DRAIN_WAIT = 20;

  typedef struct packed {
    logic [4:0]    kind;
    logic [7:0]    text;
    logic          has_byte;
    logic          done;
    logic [LW-1:0] line;
    logic [CW-1:0] col;
    logic          last;
  } token_rec_t;

  typedef struct {
    logic [7:0] c;
    logic       has;
    logic       eos;
    logic       typed;
    token_rec_t rec;
  } src_row_t;

  typedef struct {
    logic [7:0] c;
    logic       has;
    logic       eos;
  } src_item_t;

  typedef enum logic [6:0] {
    LX_IDLE  = 7'b0000001,
    LX_IDENT = 7'b0000010,
    LX_INT   = 7'b0000100,
    LX_FRAC  = 7'b0001000,
    LX_STR   = 7'b0010000,
    LX_ESC   = 7'b0100000,
    LX_SEL   = 7'b1000000
  } lex_state_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [7:0]    in_tdata;
  logic          in_tuser;
  logic          in_tlast;
  logic          out_tvalid;
  logic          out_tready;
  logic [DW-1:0] out_tdata;
  logic          out_tlast;

  token_rec_t expected_tokens[$];
  token_rec_t step_recs[$];
  src_item_t  src_q[$];
  int         fail_count;
  int         cycle_count;
  logic       rx_hold;

  // lexer model state
  lex_state_t  lx_mode;
  logic        lx_open_brace;
  logic        lx_close_brace;
  logic        lx_single_quote;
  logic [14:0] lx_kw_match;
  logic [3:0]  lx_id_len;
  logic [LW-1:0] lx_line;
  logic [CW-1:0] lx_col;
  logic [CW-1:0] lx_start_col;

  string kw_names[15] = '{"vir", "listen", "delegate", "animate", "target", "duration",
                          "easing", "begin", "when", "end", "loop", "direction", "delay",
                          "callback", "at"};
  byte   punct_set[11] = '{"{", "}", "[", "]", "(", ")", ";", ":", "=", ",", "."};

  script_token_lexer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic string fmt_rec(input token_rec_t r);
    return $sformatf("kind=%0d byte=%02h hb=%0b done=%0b line=%0d col=%0d last=%0b",
                     r.kind, r.text, r.has_byte, r.done, r.line, r.col, r.last);
  endfunction

  task automatic report_mismatch(input string what, input token_rec_t got, input token_rec_t exp);
    $display("mismatch %s: got %s, exp %s", what, fmt_rec(got), fmt_rec(exp));
    fail_count++;
  endtask

  function automatic token_rec_t mk_rec(input logic [4:0] k, input logic [7:0] b, input logic hb,
                                        input logic dn, input logic [LW-1:0] ln,
                                        input logic [CW-1:0] cl, input logic lst);
    token_rec_t r;
    r.kind = k; r.text = b; r.has_byte = hb; r.done = dn; r.line = ln; r.col = cl;
    r.last = lst;
    return r;
  endfunction

  task lex_emit(input logic [4:0] k, input logic [7:0] b, input logic hb, input logic dn,
                input logic [LW-1:0] ln, input logic [CW-1:0] cl);
    if (step_recs.size() < stl_pkg::MAX_RES)
      step_recs.insert(step_recs.size(), mk_rec(k, b, hb, dn, ln, cl, 1'b0));
  endtask

  task byte_out(input logic [7:0] b);
    lex_emit(stl_pkg::KIND_IDENT, b, 1'b1, 1'b0, '0, '0);
  endtask

  task close_out(input logic [4:0] k);
    lex_emit(k, 8'h00, 1'b0, 1'b1, lx_line, lx_start_col);
  endtask

  task col_advance;
    if (lx_col != '1) lx_col = lx_col + 1'b1;
  endtask

  task lex_clear;
    lx_mode = LX_IDLE;
    lx_open_brace = 1'b0;
    lx_close_brace = 1'b0;
    lx_single_quote = 1'b0;
    lx_kw_match = '1;
    lx_id_len = '0;
    lx_line = LW'(1);
    lx_col = CW'(1);
    lx_start_col = CW'(1);
  endtask

  function automatic logic alpha_c(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic digit_c(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task ident_grow(input logic [7:0] c);
    for (int k = 0; k < 15; k++) begin
      if (lx_kw_match[k]) begin
        if (lx_id_len >= kw_names[k].len() || kw_names[k][lx_id_len] != c)
          lx_kw_match[k] = 1'b0;
      end
    end
    if (lx_id_len != 4'd15) lx_id_len = lx_id_len + 1'b1;
  endtask

  function automatic logic [4:0] ident_class(input logic [14:0] m, input logic [3:0] len);
    for (int k = 0; k < 15; k++)
      if (m[k] && kw_names[k].len() == len) return 5'(k + 1);
    return stl_pkg::KIND_IDENT;
  endfunction

  task lex_between(input logic [7:0] c);
    logic [4:0] pk;
    if (c == " " || (c >= 8'h09 && c <= 8'h0d)) begin
      if (c == 8'h0a) begin
        if (lx_line != '1) lx_line = lx_line + 1'b1;
        lx_col = CW'(1);
      end else begin
        col_advance();
      end
    end else begin
      lx_start_col = lx_col;
      col_advance();
      if (alpha_c(c) || c == "_") begin
        lx_mode = LX_IDENT;
        lx_kw_match = '1;
        lx_id_len = '0;
        ident_grow(c);
        byte_out(c);
      end else if (c == "\"" || c == "'") begin
        lx_mode = LX_STR;
        lx_single_quote = (c == "'");
      end else if (digit_c(c)) begin
        lx_mode = LX_INT;
        byte_out(c);
      end else if (c == "{") begin
        lx_open_brace = 1'b1;
      end else begin
        pk = stl_pkg::KIND_UNKNOWN;
        for (int k = 0; k < 11; k++)
          if (punct_set[k] == c) pk = 5'(stl_pkg::KIND_LBRACE + k);
        lex_emit(pk, c, 1'b1, 1'b1, lx_line, lx_start_col);
      end
    end
  endtask

  task lex_char(input logic [7:0] c);
    case (lx_mode)
      LX_IDENT: begin
        if (alpha_c(c) || digit_c(c) || c == "_") begin
          ident_grow(c); byte_out(c); col_advance();
        end else begin
          close_out(ident_class(lx_kw_match, lx_id_len)); lx_mode = LX_IDLE; lex_between(c);
        end
      end
      LX_INT: begin
        if (digit_c(c)) begin
          byte_out(c); col_advance();
        end else if (c == ".") begin
          byte_out(c); col_advance(); lx_mode = LX_FRAC;
        end else begin
          close_out(stl_pkg::KIND_NUMBER); lx_mode = LX_IDLE; lex_between(c);
        end
      end
      LX_FRAC: begin
        if (digit_c(c)) begin
          byte_out(c); col_advance();
        end else begin
          close_out(stl_pkg::KIND_NUMBER); lx_mode = LX_IDLE; lex_between(c);
        end
      end
      LX_STR: begin
        col_advance();
        if (c == (lx_single_quote ? 8'h27 : 8'h22)) begin
          close_out(stl_pkg::KIND_STRING); lx_mode = LX_IDLE;
        end else if (c == 8'h5c) begin
          lx_mode = LX_ESC;
        end else begin
          byte_out(c);
        end
      end
      LX_ESC: begin
        col_advance(); byte_out(c); lx_mode = LX_STR;
      end
      LX_SEL: begin
        col_advance();
        if (lx_close_brace && c == "}") begin
          lx_close_brace = 1'b0;
          close_out(stl_pkg::KIND_SELECTOR); lx_mode = LX_IDLE;
        end else begin
          if (lx_close_brace) begin
            lx_close_brace = 1'b0;
            byte_out("}");
          end
          if (c == "}") lx_close_brace = 1'b1;
          else byte_out(c);
        end
      end
      default: begin
        lx_mode = LX_IDLE;
        if (lx_open_brace && c == "{") begin
          lx_open_brace = 1'b0;
          lx_mode = LX_SEL;
          lx_close_brace = 1'b0;
          col_advance();
        end else begin
          if (lx_open_brace) begin
            lx_open_brace = 1'b0;
            lex_emit(stl_pkg::KIND_LBRACE, "{", 1'b1, 1'b1, lx_line, lx_start_col);
          end
          lex_between(c);
        end
      end
    endcase
  endtask

  // runs one request through the model, leaves its records in step_recs
  task lex_predict(input src_item_t it);
    step_recs.delete();
    if (it.has) lex_char(it.c);
    if (it.eos) begin
      case (lx_mode)
        LX_IDENT: close_out(ident_class(lx_kw_match, lx_id_len));
        LX_INT, LX_FRAC: close_out(stl_pkg::KIND_NUMBER);
        LX_STR, LX_ESC: close_out(stl_pkg::KIND_STRING);
        LX_SEL: begin
          if (lx_close_brace) byte_out("}");
          close_out(stl_pkg::KIND_SELECTOR);
        end
        default: begin
          if (lx_open_brace)
            lex_emit(stl_pkg::KIND_LBRACE, "{", 1'b1, 1'b1, lx_line, lx_start_col);
        end
      endcase
      lex_emit(stl_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1, lx_line, lx_col);
      lex_clear();
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
  endtask

  task send_item(input src_item_t it);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
          ($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 3));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= it.c;
    in_tuser <= it.has;
    in_tlast <= it.eos;
    do @(posedge clk); while (!in_tready);
  endtask

  task push_byte(input logic [7:0] c);
    src_item_t it;
    it.c = c; it.has = 1'b1; it.eos = 1'b0;
    src_q.insert(src_q.size(), it);
  endtask

  task push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // builds one source of random tokens, mostly well formed
  task build_source;
    int n;
    int len;
    src_item_t it;
    n = $urandom_range(2, 8);
    for (int t = 0; t < n; t++) begin
      case ($urandom_range(0, 10))
        0, 1: push_text(kw_names[$urandom_range(0, 14)]);
        2: begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 6);
          push_byte($urandom_range(0, 1) ? "_" : 8'($urandom_range("a", "z")));
          for (int i = 1; i < len; i++)
            case ($urandom_range(0, 3))
              0: push_byte(8'($urandom_range("0", "9")));
              1: push_byte(8'($urandom_range("A", "Z")));
              default: push_byte(8'($urandom_range("a", "z")));
            endcase
        end
        3: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) push_byte(8'($urandom_range("0", "9")));
          if ($urandom_range(0, 1)) begin
            push_byte(".");
            len = $urandom_range(0, 3);
            for (int i = 0; i < len; i++) push_byte(8'($urandom_range("0", "9")));
          end
        end
        4: begin
          it.c = $urandom_range(0, 1) ? "'" : "\"";
          push_byte(it.c);
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++)
            case ($urandom_range(0, 5))
              0: begin push_byte(8'h5c); push_byte(8'($urandom_range(0, 255))); end
              1: push_byte($urandom_range(0, 1) ? "'" : "\n");
              default: push_byte(8'($urandom_range(8'h20, 8'h7e)));
            endcase
          if ($urandom_range(0, 7) != 0) push_byte(it.c);
        end
        5: begin
          push_text("{{");
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++)
            push_byte($urandom_range(0, 3) == 0 ? "}" : 8'($urandom_range(8'h21, 8'h7e)));
          if ($urandom_range(0, 5) != 0) push_text("}}");
        end
        6: push_byte(punct_set[$urandom_range(0, 10)]);
        7: push_byte(8'($urandom_range(0, 255)));
        8: push_byte("{");
        default: push_byte($urandom_range(0, 1) ? "\n" : "\t");
      endcase
      if ($urandom_range(0, 3) != 0) push_byte($urandom_range(0, 3) == 0 ? "\n" : " ");
      if ($urandom_range(0, 15) == 0) begin
        it.c = 8'($urandom_range(0, 255)); it.has = 1'b0; it.eos = 1'b0;
        src_q.insert(src_q.size(), it);
      end
    end
    if ($urandom_range(0, 1) || src_q.size() == 0) begin
      it.c = 8'($urandom_range(0, 255)); it.has = 1'b0; it.eos = 1'b1;
      src_q.insert(src_q.size(), it);
    end else begin
      src_q[src_q.size() - 1].eos = 1'b1;
    end
  endtask

  src_row_t directed_rows[$];

  task add_row(input logic [7:0] c, input logic has, input logic eos);
    src_row_t r;
    r.c = c; r.has = has; r.eos = eos; r.typed = 1'b0; r.rec = '0;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  task add_typed(input logic [7:0] c, input logic has, input logic eos, input token_rec_t rec);
    src_row_t r;
    r.c = c; r.has = has; r.eos = eos; r.typed = 1'b1; r.rec = rec;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  task run_item(input src_item_t it, input logic typed, input token_rec_t rec);
    send_item(it);
    lex_predict(it);
    if (typed) begin
      if (step_recs.size() != 1 || step_recs[0] != rec) begin
        $display("mismatch model vs table at byte %02h", it.c);
        fail_count++;
      end
      expected_tokens.insert(expected_tokens.size(), rec);
    end else begin
      foreach (step_recs[i]) expected_tokens.insert(expected_tokens.size(), step_recs[i]);
    end
  endtask

  initial begin
    src_item_t it;
    int sent;
    string sel_text;
    fail_count = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    lex_clear();

    // zero byte, punctuator, bare eof and an 0xff byte with typed results
    add_typed(8'h00, 1'b1, 1'b0, mk_rec(stl_pkg::KIND_UNKNOWN, 8'h00, 1'b1, 1'b1,
                                         LW'(1), CW'(1), 1'b1));
    add_typed("(", 1'b1, 1'b0, mk_rec(stl_pkg::KIND_LPAREN, "(", 1'b1, 1'b1,
                                       LW'(1), CW'(2), 1'b1));
    add_typed(8'h00, 1'b0, 1'b1, mk_rec(stl_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1,
                                         LW'(1), CW'(3), 1'b1));
    add_typed(8'hff, 1'b1, 1'b0, mk_rec(stl_pkg::KIND_UNKNOWN, 8'hff, 1'b1, 1'b1,
                                         LW'(1), CW'(1), 1'b1));
    // selector with an inner single close brace
    sel_text = "{{a}b}}";
    for (int i = 0; i < sel_text.len(); i++) add_row(sel_text[i], 1'b1, 1'b0);
    // lone brace, newline and a request without a byte
    add_row("{", 1'b1, 1'b0);
    add_row("x", 1'b1, 1'b0);
    add_row(8'h0a, 1'b1, 1'b0);
    add_row(8'h00, 1'b0, 1'b0);
    // escaped quote in single-quoted string, then a fractional number and an opening double quote
    add_row("'", 1'b1, 1'b0);
    add_row(8'h5c, 1'b1, 1'b0);
    add_row("'", 1'b1, 1'b0);
    add_row("'", 1'b1, 1'b0);
    add_row("1", 1'b1, 1'b0);
    add_row(".", 1'b1, 1'b0);
    add_row("5", 1'b1, 1'b0);
    add_row("\"", 1'b1, 1'b0);
    // string left open after a lone backslash at end of source, and an unclosed selector
    add_row(8'h5c, 1'b1, 1'b1);
    add_row("{", 1'b1, 1'b0);
    add_row("{", 1'b1, 1'b0);
    add_row("}", 1'b1, 1'b1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      it.c = directed_rows[i].c; it.has = directed_rows[i].has; it.eos = directed_rows[i].eos;
      run_item(it, directed_rows[i].typed, directed_rows[i].rec);
    end

    sent = 0;
    while (sent < NUM_RAND) begin
      build_source();
      while (src_q.size() > 0 && sent < NUM_RAND) begin
        it = src_q.pop_front();
        run_item(it, 1'b0, '0);
        if (it.has || it.eos) sent++;
      end
    end
    in_tvalid <= 1'b0;

    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // long receiver stall early in the random part so the output queue fills
  initial begin
    rx_hold = 1'b0;
    repeat (200) @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial out_tready = 1'b0;

  always @(posedge clk) begin
    token_rec_t got;
    token_rec_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = mk_rec(out_tdata[4:0], out_tdata[12:5], out_tdata[13], out_tdata[14],
                   out_tdata[34:15], out_tdata[50:35], out_tlast);
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected record", got, '0);
      end else begin
        exp = expected_tokens.pop_front();
        if (got.kind != exp.kind) report_mismatch("kind", got, exp);
        else if (got.text != exp.text) report_mismatch("text byte", got, exp);
        else if (got.has_byte != exp.has_byte) report_mismatch("has byte", got, exp);
        else if (got.done != exp.done) report_mismatch("token done", got, exp);
        else if (got.line != exp.line) report_mismatch("line", got, exp);
        else if (got.col != exp.col) report_mismatch("column", got, exp);
        else if (got.last != exp.last) report_mismatch("last", got, exp);
      end
    end
    if (rx_hold) out_tready <= 1'b0;
    else if ($urandom_range(0, 3) != 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 7) == 0) ? 1'b1 : 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
